FILE: rtl/core/rar_pkg.sv
// Shared types, widths, operation codes and sign/magnitude helpers
// for the rational arithmetic reduce core. No dependencies.
package rar_pkg;

	localparam int OPERAND_WIDTH = 16;
	// operand magnitude: |-2^(W-1)| needs one bit more than the field
	localparam int OP_MAG_W = OPERAND_WIDTH + 1;
	// product of two operand magnitudes, and room for the sum of two products
	localparam int MAG_W = 2 * OP_MAG_W;
	localparam int ALU_W = MAG_W + 1;
	localparam int NUM_W = 33;
	localparam int DEN_W = 32;
	localparam int EXT_W = ((MAG_W > NUM_W) ? MAG_W : NUM_W) + 1;
	localparam int CNT_W = $clog2(MAG_W);

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0]                       req_type;
		logic signed [OPERAND_WIDTH-1:0]  a_num;
		logic signed [OPERAND_WIDTH-1:0]  a_den;
		logic signed [OPERAND_WIDTH-1:0]  b_num;
		logic signed [OPERAND_WIDTH-1:0]  b_den;
	} req_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		logic                    err;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} stat_t;

	function automatic logic [OP_MAG_W-1:0] sm_mag(input logic [OPERAND_WIDTH-1:0] f);
		logic [OP_MAG_W-1:0] e;
		e = {f[OPERAND_WIDTH-1], f};
		return f[OPERAND_WIDTH-1] ? (~e + OP_MAG_W'(1)) : e;
	endfunction

	// two's complement of a sign/magnitude value, wide enough for any output field
	function automatic logic [EXT_W-1:0] sm_to_tc(input logic neg, input logic [MAG_W-1:0] m);
		logic [EXT_W-1:0] e;
		e = EXT_W'(m);
		if (neg) begin
			e = -e;
		end
		return e;
	endfunction

endpackage

FILE: rtl/core/rar_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on rar_pkg for field widths.
interface rar_req_if;
	import rar_pkg::*;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic signed [OPERAND_WIDTH-1:0]  a_num;
	logic signed [OPERAND_WIDTH-1:0]  a_den;
	logic signed [OPERAND_WIDTH-1:0]  b_num;
	logic signed [OPERAND_WIDTH-1:0]  b_den;

	modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_res_if;
	import rar_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [NUM_W-1:0]  res_num;
	logic signed [DEN_W-1:0]  res_den;
	logic                     error;

	modport source (output valid, res_num, res_den, error, input ready);
	modport sink (input valid, res_num, res_den, error, output ready);
endinterface

FILE: rtl/core/rar_alu.sv
// Shared add/subtract unit with unsigned compare (a >= b on subtract).
// Depends on rar_pkg for ALU_W.
module rar_alu (
	input  logic [rar_pkg::ALU_W-1:0] a,
	input  logic [rar_pkg::ALU_W-1:0] b,
	input  logic                      sub,
	output logic [rar_pkg::ALU_W-1:0] sum,
	output logic                      ge
);
	import rar_pkg::*;

	logic [ALU_W:0] t;

	always_comb begin
		t = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
	end

	assign sum = t[ALU_W-1:0];
	// carry out of a + ~b + 1 means no borrow
	assign ge  = t[ALU_W];
endmodule

FILE: rtl/core/rar_engine.sv
// Sequencer and datapath: operand reduction, products, signed sum and
// result reduction by binary gcd and restoring division on rar_alu.
// Depends on rar_pkg and rar_alu.
module rar_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rar_pkg::req_t  req,
	input  logic           out_free,
	output rar_pkg::stat_t stat,
	output rar_pkg::res_t  res
);
	import rar_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RS   = 4'd1;
	localparam logic [3:0] S_GCD  = 4'd2;
	localparam logic [3:0] S_GSH  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_MX   = 4'd6;
	localparam logic [3:0] S_MY   = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;
	localparam logic [3:0] S_MD   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_R = 2'd2;

	logic [3:0]          state_q, state_d;
	logic [1:0]          ph_q;
	logic [1:0]          op_q;
	logic                err_q;
	logic                eq_q;
	logic [OP_MAG_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic                an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [MAG_W-1:0]    x_q, y_q, u_q, v_q, r_q;
	logic                xs_q, ys_q;
	logic [CNT_W-1:0]    k_q, cnt_q;
	logic                dsel_q;

	logic                in_err;
	logic                den_eq;
	logic                add_done;
	logic                div_last;
	logic [OP_MAG_W-1:0] ma, mb;
	logic                psign;
	logic [MAG_W-1:0]    prod;
	logic [ALU_W-1:0]    rem_sh;
	logic [ALU_W-1:0]    alu_a, alu_b, alu_sum;
	logic                alu_sub, alu_ge;
	logic                qbit;
	logic                res_err;
	logic [EXT_W-1:0]    num_ext, den_ext;

	assign in_err = (req.a_den == '0) || (req.b_den == '0) || (req.req_type == OP_RSVD);
	assign den_eq = (ad_s_q == bd_s_q) && (ad_q == bd_q);
	assign rem_sh = {r_q, (dsel_q ? y_q[MAG_W-1] : x_q[MAG_W-1])};
	assign div_last = (cnt_q == CNT_W'(MAG_W - 1));
	assign add_done = (xs_q == ys_q) || alu_ge;
	assign qbit = alu_ge;

	// multiplier operand selection
	always_comb begin
		ma = ad_q;
		mb = bd_q;
		psign = ad_s_q ^ bd_s_q;
		case (state_q)
			S_MX: begin
				ma = an_q;
				mb = (op_q == OP_MUL) ? bn_q : bd_q;
				psign = an_s_q ^ ((op_q == OP_MUL) ? bn_s_q : bd_s_q);
			end
			S_MY: begin
				ma = ad_q;
				mb = bn_q;
				psign = ad_s_q ^ bn_s_q;
			end
			S_MD: begin
				ma = ad_q;
				mb = (op_q == OP_DIV) ? bn_q : bd_q;
				psign = ad_s_q ^ ((op_q == OP_DIV) ? bn_s_q : bd_s_q);
			end
			default: begin
				ma = ad_q;
				mb = bd_q;
				psign = ad_s_q ^ bd_s_q;
			end
		endcase
	end

	assign prod = ma * mb;

	// shared unit operand selection
	always_comb begin
		alu_a = {1'b0, u_q};
		alu_b = {1'b0, v_q};
		alu_sub = 1'b1;
		case (state_q)
			S_GCD: begin
				alu_a = {1'b0, u_q};
				alu_b = {1'b0, v_q};
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a = rem_sh;
				alu_b = {1'b0, v_q};
				alu_sub = 1'b1;
			end
			S_ADD: begin
				alu_a = {1'b0, x_q};
				alu_b = {1'b0, y_q};
				alu_sub = (xs_q != ys_q);
			end
			default: begin
				alu_a = {1'b0, u_q};
				alu_b = {1'b0, v_q};
				alu_sub = 1'b1;
			end
		endcase
	end

	rar_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum),
		.ge  (alu_ge)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = in_err ? S_FIN : S_RS;
				end
			end
			S_RS: begin
				state_d = ((x_q == '0) || (y_q == '0)) ? S_RD : S_GCD;
			end
			S_GCD: begin
				if (u_q == '0) begin
					state_d = S_GSH;
				end
			end
			S_GSH: begin
				if (k_q == '0) begin
					state_d = (v_q == MAG_W'(1)) ? S_RD : S_DIV;
				end
			end
			S_DIV: begin
				if (div_last && dsel_q) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				case (ph_q)
					PH_A: state_d = S_RS;
					PH_B: state_d = S_MX;
					default: state_d = S_FIN;
				endcase
			end
			S_MX: begin
				if (op_q == OP_ADD) begin
					state_d = den_eq ? S_ADD : S_MY;
				end else begin
					state_d = S_MD;
				end
			end
			S_MY: state_d = S_ADD;
			S_ADD: begin
				if (add_done) begin
					state_d = S_MD;
				end
			end
			S_MD: state_d = S_RS;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q   <= req.req_type;
					err_q  <= in_err;
					ph_q   <= PH_A;
					an_s_q <= req.a_num[OPERAND_WIDTH-1];
					ad_s_q <= req.a_den[OPERAND_WIDTH-1];
					bn_s_q <= req.b_num[OPERAND_WIDTH-1];
					bd_s_q <= req.b_den[OPERAND_WIDTH-1];
					an_q   <= sm_mag(req.a_num);
					ad_q   <= sm_mag(req.a_den);
					bn_q   <= sm_mag(req.b_num);
					bd_q   <= sm_mag(req.b_den);
					x_q    <= MAG_W'(sm_mag(req.a_num));
					y_q    <= MAG_W'(sm_mag(req.a_den));
				end
			end
			S_RS: begin
				u_q <= x_q;
				v_q <= y_q;
				k_q <= '0;
			end
			S_GCD: begin
				if (u_q == '0) begin
					// v holds the odd part of the gcd
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + CNT_W'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (alu_ge) begin
					u_q <= alu_sum[MAG_W-1:0];
				end else begin
					u_q <= v_q;
					v_q <= u_q;
				end
			end
			S_GSH: begin
				// restore the common powers of two
				if (k_q != '0) begin
					v_q <= v_q << 1;
					k_q <= k_q - CNT_W'(1);
				end else begin
					cnt_q  <= '0;
					r_q    <= '0;
					dsel_q <= 1'b0;
				end
			end
			S_DIV: begin
				r_q <= qbit ? alu_sum[MAG_W-1:0] : rem_sh[MAG_W-1:0];
				if (dsel_q) begin
					y_q <= {y_q[MAG_W-2:0], qbit};
				end else begin
					x_q <= {x_q[MAG_W-2:0], qbit};
				end
				if (div_last) begin
					cnt_q  <= '0;
					dsel_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_RD: begin
				case (ph_q)
					PH_A: begin
						an_q <= x_q[OP_MAG_W-1:0];
						ad_q <= y_q[OP_MAG_W-1:0];
						x_q  <= MAG_W'(bn_q);
						y_q  <= MAG_W'(bd_q);
						ph_q <= PH_B;
					end
					PH_B: begin
						bn_q <= x_q[OP_MAG_W-1:0];
						bd_q <= y_q[OP_MAG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			S_MX: begin
				eq_q <= den_eq;
				if ((op_q == OP_ADD) && den_eq) begin
					x_q  <= MAG_W'(an_q);
					xs_q <= an_s_q;
					y_q  <= MAG_W'(bn_q);
					ys_q <= bn_s_q;
				end else begin
					x_q  <= prod;
					xs_q <= psign;
				end
			end
			S_MY: begin
				y_q  <= prod;
				ys_q <= psign;
			end
			S_ADD: begin
				if (add_done) begin
					x_q <= alu_sum[MAG_W-1:0];
				end else begin
					// swap so the larger magnitude is subtracted from
					x_q  <= y_q;
					y_q  <= x_q;
					xs_q <= ys_q;
					ys_q <= xs_q;
				end
			end
			S_MD: begin
				if ((op_q == OP_ADD) && eq_q) begin
					y_q  <= MAG_W'(ad_q);
					ys_q <= ad_s_q;
				end else begin
					y_q  <= prod;
					ys_q <= psign;
				end
				ph_q <= PH_R;
			end
			default: begin
			end
		endcase
	end

	assign res_err = err_q || (y_q == '0);
	assign num_ext = sm_to_tc(xs_q, x_q);
	assign den_ext = sm_to_tc(ys_q, y_q);

	always_comb begin
		res.err = res_err;
		res.num = res_err ? '0 : $signed(num_ext[NUM_W-1:0]);
		res.den = res_err ? '0 : $signed(den_ext[DEN_W-1:0]);
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_FIN) && out_free;
endmodule

FILE: rtl/core/rational_arith_reduce_core.sv
// Rational add/multiply/divide with gcd reduction: one item at a time. An item that is
// rejected at the door (zero operand denominator or code 3) skips all work; otherwise
// three reductions run back to back (each operand, then the result), each a binary
// gcd plus, when the gcd is not 1, two restoring divisions of 2W+2 quotient bits each,
// W being the operand width, all on the one shared add/subtract unit; the products and
// the signed sum are formed between the operand and the result reductions.
// Input ready is held low from acceptance until the result enters the output register,
// and the next item is taken while that result waits to be read.
// Depends on rar_pkg, rar_if, rar_engine.
module rational_arith_reduce_core (
	input logic    clk,
	input logic    arst_n,
	rar_req_if.sink   req,
	rar_res_if.source res
);
	import rar_pkg::*;

	req_t  eng_req;
	stat_t eng_stat;
	res_t  eng_res;
	res_t  out_q;
	logic  out_valid_q;
	logic  out_free;
	logic  start;

	assign eng_req.req_type = req.req_type;
	assign eng_req.a_num    = req.a_num;
	assign eng_req.a_den    = req.a_den;
	assign eng_req.b_num    = req.b_num;
	assign eng_req.b_den    = req.b_den;

	assign req.ready = eng_stat.idle;
	assign start     = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;

	rar_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (eng_req),
		.out_free (out_free),
		.stat     (eng_stat),
		.res      (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_stat.done) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.done) begin
			out_q <= eng_res;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.res_num = out_q.num;
	assign res.res_den = out_q.den;
	assign res.error   = out_q.err;

	// check that ready drops once an item is accepted
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req.ready)
		else $error("input ready high right after a transaction");

	// never overwrite a result that has not been taken
	a_done_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.done |-> out_free)
		else $error("result finished while output register is occupied");

	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.error) |-> ((res.res_num == '0) && (res.res_den == '0)))
		else $error("error result with nonzero fields");
endmodule
